/* rtl/scs_pkg.sv */
// Shared types and constants for the sleep countdown table.
package scs_pkg;

  localparam int unsigned SLOTS = 16;
  localparam int unsigned IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CNT_W = $clog2(SLOTS + 1);

  localparam logic ACT_SLEEP = 1'b0;
  localparam logic ACT_TICK  = 1'b1;

  localparam logic KIND_WOKEN  = 1'b0;
  localparam logic KIND_REJECT = 1'b1;

  typedef struct packed {
    logic        action;
    logic [7:0]  thread_id;
    logic [31:0] ticks;
  } req_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] woken_id;
    logic       last;
  } rsp_t;

  typedef struct packed {
    logic [7:0]  id;
    logic [31:0] remaining;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  // Events from the table controller to the result stage.
  typedef struct packed {
    logic       wake;
    logic       reject;
    logic       done;
    logic [7:0] id;
  } ev_t;

endpackage

/* rtl/scs_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module scs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/scs_ctrl.sv */
// Table controller: appends sleepers and runs the countdown/compaction scan.
module scs_ctrl (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  scs_pkg::req_t req_i,
  output logic         busy_o,
  output scs_pkg::ev_t  ev_o
);
  import scs_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_FINISH} state_e;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] r_q, r_d;
  logic [CNT_W-1:0] w_q, w_d;

  logic             we, re;
  logic [IDX_W-1:0] waddr, raddr;
  entry_t           wdata, rdata;
  logic             expired;
  ev_t              ev;

  scs_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(SLOTS)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (re),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign expired = (rdata.remaining[31:1] == 31'd0);

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    r_d     = r_q;
    w_d     = w_q;
    we      = 1'b0;
    re      = 1'b0;
    waddr   = count_q[IDX_W-1:0];
    wdata   = '{id: req_i.thread_id, remaining: req_i.ticks};
    raddr   = '0;
    ev      = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          if (req_i.action == ACT_TICK) begin
            if (count_q != '0) begin
              re      = 1'b1;
              r_d     = CNT_W'(1);
              w_d     = '0;
              state_d = ST_SCAN;
            end
          end else if (req_i.ticks != 32'd0) begin
            if (count_q < CNT_W'(SLOTS)) begin
              we      = 1'b1;
              count_d = count_q + CNT_W'(1);
            end else begin
              ev.reject = 1'b1;
              ev.id     = req_i.thread_id;
            end
          end
        end
      end
      ST_SCAN: begin
        // Survivors are written back at w, never ahead of the read pointer.
        if (expired) begin
          ev.wake = 1'b1;
          ev.id   = rdata.id;
        end else begin
          we    = 1'b1;
          waddr = w_q[IDX_W-1:0];
          wdata = '{id: rdata.id, remaining: rdata.remaining - 32'd1};
          w_d   = w_q + CNT_W'(1);
        end
        if (r_q < count_q) begin
          re    = 1'b1;
          raddr = r_q[IDX_W-1:0];
          r_d   = r_q + CNT_W'(1);
        end else begin
          count_d = w_d;
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        ev.done = 1'b1;
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      r_q     <= '0;
      w_q     <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      r_q     <= r_d;
      w_q     <= w_d;
    end
  end

  assign busy_o = (state_q != ST_IDLE);
  assign ev_o   = ev;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(SLOTS))
    else $error("sleeper count above table size");

  a_wb_behind_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN && we) |-> (w_q < r_q))
    else $error("compaction write overtook read pointer");

  a_reject_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ev.reject |-> (count_q == CNT_W'(SLOTS) && state_q == ST_IDLE))
    else $error("reject while table not full");

  a_scan_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FINISH) |-> (count_q <= $past(count_q, 2) || $past(state_q) == ST_SCAN))
    else $error("scan grew the table");

endmodule

/* rtl/sleep_countdown_table_unit.sv */
// Top level of the sleep countdown table: controller plus result stage.
//
// A request is taken on a rising edge with start_i high and busy_o low.
// A sleep request (action 0) with nonzero ticks is appended to the
// table in that same cycle and busy_o stays low; with zero ticks it
// is dropped. If the table already holds SLOTS sleepers, one rejected
// result (kind 1, last 1) appears on res_o in the cycle after the request.
// A tick (action 1) scans the table once through the table memory's read
// port, one entry per cycle; busy_o stays high until the scan is done
// and stays low when the table is empty. Each entry is decremented;
// expired entries are removed, survivors are compacted in order. Woken
// thread numbers leave in insertion order, each for one cycle with
// res_valid_o high; the last one is held back one entry so it can carry
// last = 1, and it is on res_o in the first cycle with busy_o low.
// A tick that wakes nobody gives no result.
// Results cannot be stalled by the receiver. Reset empties the table and
// drops any pending result; table contents need no clearing.
module sleep_countdown_table_unit (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  scs_pkg::req_t req_i,
  output logic          busy_o,
  output logic          res_valid_o,
  output scs_pkg::rsp_t res_o
);
  import scs_pkg::*;

  ev_t        ev;
  logic       pend_vld_q, pend_vld_d;
  logic [7:0] pend_id_q, pend_id_d;
  logic       out_vld_q, out_vld_d;
  rsp_t       rsp_q, rsp_d;

  scs_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .req_i  (req_i),
    .busy_o (busy_o),
    .ev_o   (ev)
  );

  // A woken id waits here until the next wake or the end of the scan.
  always_comb begin
    pend_vld_d = pend_vld_q;
    pend_id_d  = pend_id_q;
    out_vld_d  = 1'b0;
    rsp_d      = rsp_q;
    if (ev.reject) begin
      out_vld_d = 1'b1;
      rsp_d     = '{kind: KIND_REJECT, woken_id: ev.id, last: 1'b1};
    end else if (ev.wake) begin
      if (pend_vld_q) begin
        out_vld_d = 1'b1;
        rsp_d     = '{kind: KIND_WOKEN, woken_id: pend_id_q, last: 1'b0};
      end
      pend_vld_d = 1'b1;
      pend_id_d  = ev.id;
    end else if (ev.done && pend_vld_q) begin
      out_vld_d  = 1'b1;
      rsp_d      = '{kind: KIND_WOKEN, woken_id: pend_id_q, last: 1'b1};
      pend_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      pend_vld_q <= pend_vld_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_id_q <= pend_id_d;
    rsp_q     <= rsp_d;
  end

  assign res_valid_o = out_vld_q;
  assign res_o       = rsp_q;

endmodule

/* bench/tb_sleep_countdown_table_unit.sv */
// Self-checking bench for the sleep countdown table: directed rows, then random sleep/tick traffic.
`timescale 1ns / 100ps

module tb_sleep_countdown_table_unit;
  import scs_pkg::*;

  logic clk_i;
  logic rst_ni;
  logic start_i;
  req_t req_i;
  logic busy_o;
  logic res_valid_o;
  rsp_t res_o;

  sleep_countdown_table_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .req_i      (req_i),
    .busy_o     (busy_o),
    .res_valid_o(res_valid_o),
    .res_o      (res_o)
  );

  typedef struct {
    req_t req;
    int   typed_n;  // -1: no typed-in expectation
    rsp_t typed;
  } dir_row_t;

  // Shadow of the sleeper table.
  logic [7:0]  nap_id   [SLOTS];
  logic [31:0] nap_left [SLOTS];
  int unsigned nap_cnt;

  rsp_t     awaited_rsp[$];
  dir_row_t dir_rows[$];

  int mismatch_cnt;
  int item_cnt;
  int sleeps_stored, rejects_seen, ignored_cnt, tick_cnt, wake_cnt, max_wakes, typed_cnt;
  bit no_idle;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("run timed out, %0d results still awaited", awaited_rsp.size());
    $display("tb_sleep_countdown_table_unit NOT OK");
    $finish;
  end

  task automatic flag_error(string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= 10) $display("[%0t] ERROR %s", $realtime, msg);
  endtask

  // Applies one accepted request to the shadow table; queues the results it causes.
  function automatic int apply_request(req_t r);
    rsp_t        e;
    int unsigned keep;
    int          n;
    n = 0;
    if (r.action == ACT_SLEEP) begin
      if (r.ticks == '0) return 0;
      if (nap_cnt >= SLOTS) begin
        e.kind     = KIND_REJECT;
        e.woken_id = r.thread_id;
        e.last     = 1'b1;
        awaited_rsp.push_back(e);
        return 1;
      end
      nap_id[nap_cnt]   = r.thread_id;
      nap_left[nap_cnt] = r.ticks;
      nap_cnt++;
      return 0;
    end
    keep = 0;
    for (int i = 0; i < int'(nap_cnt); i++) begin
      if (nap_left[i] <= 32'd1) begin
        e.kind     = KIND_WOKEN;
        e.woken_id = nap_id[i];
        e.last     = 1'b0;
        awaited_rsp.push_back(e);
        n++;
      end else begin
        nap_id[keep]   = nap_id[i];
        nap_left[keep] = nap_left[i] - 32'd1;
        keep++;
      end
    end
    nap_cnt = keep;
    if (n > 0) begin
      e = awaited_rsp.pop_back();
      e.last = 1'b1;
      awaited_rsp.push_back(e);
    end
    return n;
  endfunction

  // One clock edge; any result present in the cycle that just ended is checked.
  task automatic step_clock();
    rsp_t e;
    @(posedge clk_i);
    if (res_valid_o === 1'b1) begin
      if (awaited_rsp.size() == 0) begin
        flag_error($sformatf("unexpected result kind %0d id %02h last %0d",
                             res_o.kind, res_o.woken_id, res_o.last));
      end else begin
        e = awaited_rsp.pop_front();
        if (res_o.kind !== e.kind || res_o.woken_id !== e.woken_id || res_o.last !== e.last)
          flag_error($sformatf("expected kind %0d id %02h last %0d, got kind %0d id %02h last %0d",
                               e.kind, e.woken_id, e.last,
                               res_o.kind, res_o.woken_id, res_o.last));
      end
    end
  endtask

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  function automatic req_t mk_req(logic act, logic [7:0] id, logic [31:0] t);
    req_t r;
    r.action    = act;
    r.thread_id = id;
    r.ticks     = t;
    return r;
  endfunction

  // Drives one request until taken, updates the shadow table, then idles for a random gap, which may be none.
  task automatic issue(req_t r, int typed_n, rsp_t typed);
    int n;
    int gap;
    start_i <= 1'b1;
    req_i   <= r;
    do step_clock(); while (busy_o !== 1'b0);
    n = apply_request(r);
    if (r.action == ACT_TICK) begin
      tick_cnt++;
      wake_cnt += n;
      if (n > max_wakes) max_wakes = n;
    end else if (r.ticks == '0) begin
      ignored_cnt++;
    end else if (n > 0) begin
      rejects_seen++;
    end else begin
      sleeps_stored++;
    end
    if (!(r.action == ACT_SLEEP && r.ticks == '0)) item_cnt++;
    if (typed_n >= 0) begin
      typed_cnt++;
      if (n != typed_n || (n == 1 && awaited_rsp[$] != typed))
        flag_error($sformatf("row with action %0d id %02h: %0d results predicted, %0d typed",
                             r.action, r.thread_id, n, typed_n));
    end
    gap = pick_gap();
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) step_clock();
    end
  endtask

  task automatic add_row(logic act, logic [7:0] id, logic [31:0] t, int n,
                         logic kind, logic [7:0] wid);
    dir_row_t row;
    row.req            = mk_req(act, id, t);
    row.typed_n        = n;
    row.typed.kind     = kind;
    row.typed.woken_id = wid;
    row.typed.last     = 1'b1;
    dir_rows.push_back(row);
  endtask

  task automatic send_sleep(logic [7:0] id, logic [31:0] t);
    issue(mk_req(ACT_SLEEP, id, t), -1, '0);
  endtask

  task automatic send_tick();
    issue(mk_req(ACT_TICK, 8'($urandom_range(0, 255)), $urandom()), -1, '0);
  endtask

  // Mostly short sleeps so results keep coming; some cross carry boundaries.
  function automatic logic [31:0] short_time();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return $urandom_range(1, 4);
    if (r < 9) return $urandom_range(5, 40);
    return (32'd1 << $urandom_range(0, 6)) + $urandom_range(0, 1);
  endfunction

  initial begin
    int mode;
    int n;
    int t;
    rst_ni       = 1'b0;
    start_i      = 1'b0;
    req_i        = '0;
    nap_cnt      = 0;
    mismatch_cnt = 0;
    no_idle      = 1'b0;
    item_cnt = 0; sleeps_stored = 0; rejects_seen = 0; ignored_cnt = 0;
    tick_cnt = 0; wake_cnt = 0; max_wakes = 0; typed_cnt = 0;

    // tick on an empty table, zero-time sleep, duplicates, full table, reject
    add_row(ACT_TICK,  8'h00, 32'h0000_0000, 0, KIND_WOKEN, 8'h00);
    add_row(ACT_SLEEP, 8'hFF, 32'h0000_0000, 0, KIND_WOKEN, 8'h00);
    add_row(ACT_SLEEP, 8'h00, 32'h0000_0001, -1, KIND_WOKEN, 8'h00);
    add_row(ACT_SLEEP, 8'h5A, 32'h0000_0002, -1, KIND_WOKEN, 8'h00);
    add_row(ACT_SLEEP, 8'h5A, 32'h0000_0001, -1, KIND_WOKEN, 8'h00);
    add_row(ACT_TICK,  8'hFF, 32'hFFFF_FFFF, -1, KIND_WOKEN, 8'h00);
    add_row(ACT_TICK,  8'h00, 32'h0000_0000, -1, KIND_WOKEN, 8'h00);
    for (int i = 0; i < SLOTS; i++)
      add_row(ACT_SLEEP, 8'(8'hF0 ^ (i * 17)), 32'd1, -1, KIND_WOKEN, 8'h00);
    add_row(ACT_SLEEP, 8'hA5, 32'hFFFF_FFFF, 1, KIND_REJECT, 8'hA5);
    add_row(ACT_SLEEP, 8'h33, 32'h0000_0000, 0, KIND_WOKEN, 8'h00);
    add_row(ACT_TICK,  8'h7E, 32'h8000_0000, -1, KIND_WOKEN, 8'h00);

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) issue(dir_rows[i].req, dir_rows[i].typed_n, dir_rows[i].typed);

    item_cnt = 0;
    while (item_cnt < 450) begin
      no_idle = ($urandom_range(0, 3) == 0);
      mode    = $urandom_range(0, 9);
      if (mode <= 5) begin
        n = $urandom_range(1, 8);
        for (int k = 0; k < n; k++) begin
          if ($urandom_range(0, 9) < 3) send_tick();
          else send_sleep(8'($urandom_range(0, 255)), short_time());
        end
        t = 0;
        while (nap_cnt > 0 && t < 8) begin
          send_tick();
          t++;
        end
      end else if (mode <= 7) begin
        // fill up, overflow with rejected requests, then drain
        while (nap_cnt < SLOTS)
          send_sleep(8'($urandom_range(0, 255)), (mode == 6) ? 32'd1 : $urandom_range(1, 3));
        n = $urandom_range(1, 3);
        for (int k = 0; k < n; k++)
          send_sleep(8'($urandom_range(0, 255)), $urandom() | 32'd1);
        for (int k = 0; k < 3; k++) send_tick();
      end else begin
        // noise: random mix, zero-time sleeps included
        for (int k = 0; k < 6; k++) begin
          if ($urandom_range(0, 1) == 1) send_tick();
          else send_sleep(8'($urandom_range(0, 255)), $urandom_range(0, 2));
        end
      end
    end

    start_i <= 1'b0;
    while (awaited_rsp.size() > 0) step_clock();
    repeat (40) step_clock();

    $display("covered %0d ticks and %0d stored sleeps, %0d rejected on a full table, %0d ignored",
             tick_cnt, sleeps_stored, rejects_seen, ignored_cnt);
    $display("%0d threads woken, up to %0d on one tick; %0d typed rows, %0d mismatches",
             wake_cnt, max_wakes, typed_cnt, mismatch_cnt);
    if (mismatch_cnt == 0) begin
      $display("tb_sleep_countdown_table_unit OK");
    end else begin
      $display("tb_sleep_countdown_table_unit NOT OK");
    end
    $finish;
  end

endmodule
